// File: hw/rtl/scsw_pkg.sv
`timescale 1ns / 1ps

package scsw_pkg;

	// window length and register reset values
	localparam logic [31:0] WINDOW_MS    = 32'd60000;
	localparam logic [7:0]  STEP_LEN_RST = 8'd70;
	localparam logic [15:0] RUN_THR_RST  = 16'd130;

	// configuration address width: two 32-bit registers at byte 0 and 4
	localparam int CFG_AW = 3;

	// speed: (n*256 + 3000) / 6000 == (16*n + 187) / 375
	localparam logic [27:0] SPD_BIAS = 28'd187;
	localparam logic [8:0]  DIV_375  = 9'd375;
	// floor(2^32 / 375); quotient low by at most one, fixed by remainder check
	localparam logic [23:0] RCP_375  = 24'd11453246;

	// distance: m / 10 == (m >> 1) / 5, split in a high and a low chunk
	localparam logic [2:0]  DIV_5    = 3'd5;
	// floor(2^24 / 5) for the high chunk, floor(2^26 / 5) for the low chunk
	localparam logic [21:0] RCP_5_HI = 22'd3355443;
	localparam logic [23:0] RCP_5_LO = 24'd13421772;

	typedef enum logic {
		OP_EVENT = 1'b0,
		OP_EVAL  = 1'b1
	} op_t;

	typedef enum logic {
		REG_STEP_LEN = 1'b0,
		REG_RUN_THR  = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [7:0]  step_len;
		logic [15:0] run_thr;
	} cfg_t;

	typedef struct packed {
		logic        closed;
		logic        running;
		logic [15:0] cadence;
		logic [31:0] total;
	} meta_t;

	typedef struct packed {
		meta_t       meta;
		logic [23:0] steps_len;
		logic [39:0] total_len;
	} trk_t;

endpackage

// File: hw/rtl/scsw_if.sv
`timescale 1ns / 1ps

interface scsw_in_if;
	import scsw_pkg::*;

	logic        valid;
	logic        ready;
	op_t         op;
	logic [31:0] now_ms;
	logic        is_motion;
	logic        vibrating;

	modport source (output valid, op, now_ms, is_motion, vibrating, input ready);
	modport sink   (input valid, op, now_ms, is_motion, vibrating, output ready);
endinterface

interface scsw_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] cadence;
	logic [15:0] speed_q8;
	logic [31:0] distance_dm;
	logic        running;
	logic [31:0] step_total;
	logic        window_closed;

	modport source (output valid, cadence, speed_q8, distance_dm, running, step_total,
		window_closed, input ready);
	modport sink   (input valid, cadence, speed_q8, distance_dm, running, step_total,
		window_closed, output ready);
endinterface

// File: hw/rtl/step_cadence_speed_window_unit.sv
`timescale 1ns / 1ps

// Step counter with one-minute cadence window. Every accepted word (motion
// event or evaluate tick) gives one result word. A new word is taken every
// cycle while result.ready is held high; the depth comes from the
// reciprocal-multiply stages that divide by 6000 for speed and by 10 for
// distance, each split so that no multiplier exceeds 28 by 24 bits. Window
// count, start time and total steps are updated in the first stage, so the
// words are handled strictly in arrival order. Speed and distance saturate
// at 16 and 32 bits. Registers: step length in cm at byte 0, running
// threshold at byte 4; write them only while no word is in flight.
module step_cadence_speed_window_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [scsw_pkg::CFG_AW-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	scsw_in_if.sink                     item,
	scsw_out_if.source                  result
);
	import scsw_pkg::*;

	cfg_t cfg;
	trk_t trk;
	logic trk_valid;
	logic trk_ready;

	scsw_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	scsw_track u_track (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.item      (item),
		.trk       (trk),
		.trk_valid (trk_valid),
		.trk_ready (trk_ready)
	);

	scsw_math u_math (
		.clk       (clk),
		.arst_n    (arst_n),
		.trk       (trk),
		.trk_valid (trk_valid),
		.trk_ready (trk_ready),
		.result    (result)
	);

endmodule

// File: hw/rtl/scsw_cfg.sv
`timescale 1ns / 1ps

module scsw_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [scsw_pkg::CFG_AW-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	output scsw_pkg::cfg_t              cfg
);
	import scsw_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr;

	assign idx    = reg_idx_t'(paddr[CFG_AW-1]);
	assign wr     = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_len <= STEP_LEN_RST;
			cfg_q.run_thr  <= RUN_THR_RST;
		end else if (wr) begin
			unique case (idx)
				REG_STEP_LEN: cfg_q.step_len <= pwdata[7:0];
				REG_RUN_THR:  cfg_q.run_thr  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_STEP_LEN: prdata = {24'd0, cfg_q.step_len};
			REG_RUN_THR:  prdata = {16'd0, cfg_q.run_thr};
			default:      prdata = 32'd0;
		endcase
	end

endmodule

// File: hw/rtl/scsw_track.sv
`timescale 1ns / 1ps

module scsw_track (
	input  logic           clk,
	input  logic           arst_n,
	input  scsw_pkg::cfg_t cfg,
	scsw_in_if.sink        item,
	output scsw_pkg::trk_t trk,
	output logic           trk_valid,
	input  logic           trk_ready
);
	import scsw_pkg::*;

	logic        v_s1;
	op_t         op_s1;
	logic [31:0] now_s1;
	logic        motion_s1;
	logic        vib_s1;

	logic [15:0] count_q;
	logic [31:0] start_q;
	logic [31:0] total_q;

	logic        v_s2;
	trk_t        trk_s2;

	logic        rdy_s1;
	logic        rdy_s2;
	logic        fire;
	logic        count_step;
	logic        close;
	logic [31:0] age;
	trk_t        trk_c;

	assign rdy_s2     = ~v_s2 | trk_ready;
	assign rdy_s1     = ~v_s1 | rdy_s2;
	assign item.ready = rdy_s1;
	assign fire       = v_s1 & rdy_s2;

	assign count_step = (op_s1 == OP_EVENT) & motion_s1 & ~vib_s1;
	assign age        = now_s1 - start_q;
	assign close      = (op_s1 == OP_EVAL) & (age > WINDOW_MS);

	always_comb begin
		trk_c.meta.closed  = close;
		trk_c.meta.running = (count_q >= cfg.run_thr);
		trk_c.meta.cadence = count_q;
		trk_c.meta.total   = count_step ? total_q + 32'd1 : total_q;
		trk_c.steps_len    = 24'(count_q) * 24'(cfg.step_len);
		trk_c.total_len    = 40'(total_q) * 40'(cfg.step_len);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= item.valid;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			op_s1     <= item.op;
			now_s1    <= item.now_ms;
			motion_s1 <= item.is_motion;
			vib_s1    <= item.vibrating;
		end
		if (rdy_s2) begin
			trk_s2 <= trk_c;
		end
	end

	// window state advances once per word, in arrival order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 16'd0;
			start_q <= 32'd0;
			total_q <= 32'd0;
		end else if (fire) begin
			if (count_step) begin
				if (count_q != 16'hFFFF) begin
					count_q <= count_q + 16'd1;
				end
				total_q <= total_q + 32'd1;
			end
			if (close) begin
				count_q <= 16'd0;
				start_q <= now_s1;
			end
		end
	end

	assign trk       = trk_s2;
	assign trk_valid = v_s2;

	a_close_restart: assert property (@(posedge clk) disable iff (!arst_n)
		fire && close |=> count_q == 16'd0 && start_q == $past(now_s1))
		else $error("window not restarted after close");

	a_count_inc: assert property (@(posedge clk) disable iff (!arst_n)
		fire && count_step && count_q != 16'hFFFF |=> count_q == $past(count_q) + 16'd1)
		else $error("window count did not advance on a step");

	a_hold_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> $stable(total_q) && $stable(count_q) && $stable(start_q))
		else $error("window state moved without a word");

endmodule

// File: hw/rtl/scsw_math.sv
`timescale 1ns / 1ps

module scsw_math (
	input  logic           clk,
	input  logic           arst_n,
	input  scsw_pkg::trk_t trk,
	input  logic           trk_valid,
	output logic           trk_ready,
	scsw_out_if.source     result
);
	import scsw_pkg::*;

	// stage 3: reciprocal products
	logic        v_s3;
	meta_t       meta_s3;
	logic [27:0] y_s3;
	logic [51:0] py_s3;
	logic [18:0] a_s3;
	logic [19:0] b_s3;
	logic [40:0] pa_s3;
	// stage 4: estimates and remainders
	logic        v_s4;
	meta_t       meta_s4;
	logic [19:0] qy_s4;
	logic [9:0]  ry_s4;
	logic [16:0] qa_s4;
	logic [3:0]  ra_s4;
	logic [19:0] b_s4;
	// stage 5: speed done, low distance chunk product
	logic        v_s5;
	meta_t       meta_s5;
	logic [15:0] speed_s5;
	logic [16:0] qa_s5;
	logic [22:0] w_s5;
	logic [46:0] pw_s5;
	// stage 6: low chunk estimate
	logic        v_s6;
	meta_t       meta_s6;
	logic [15:0] speed_s6;
	logic [16:0] qa_s6;
	logic [19:0] qw_s6;
	logic [3:0]  rw_s6;
	// stage 7: result register
	logic        v_s7;
	logic [15:0] cad_s7;
	logic [15:0] spd_s7;
	logic [31:0] dist_s7;
	logic        run_s7;
	logic [31:0] total_s7;
	logic        closed_s7;

	logic [15:0] last_cad_q;
	logic [15:0] last_spd_q;
	logic [31:0] last_dist_q;
	logic        last_run_q;

	logic        rdy_s3, rdy_s4, rdy_s5, rdy_s6, rdy_s7;

	logic [27:0] y_c;
	logic [51:0] py_c;
	logic [18:0] a_c;
	logic [19:0] b_c;
	logic [40:0] pa_c;
	logic [19:0] qy_c;
	logic [9:0]  ry_c;
	logic [16:0] qa_c;
	logic [3:0]  ra_c;
	logic [19:0] spd_c;
	logic [15:0] speed_c;
	logic        ra_hi;
	logic [16:0] qa_fix;
	logic [3:0]  ra_fix;
	logic [22:0] w_c;
	logic [46:0] pw_c;
	logic [19:0] qw_c;
	logic [3:0]  rw_c;
	logic [19:0] qw_fix;
	logic [36:0] dist_w;
	logic [31:0] dist_c;
	logic        take_s6;

	assign rdy_s7    = ~v_s7 | result.ready;
	assign rdy_s6    = ~v_s6 | rdy_s7;
	assign rdy_s5    = ~v_s5 | rdy_s6;
	assign rdy_s4    = ~v_s4 | rdy_s5;
	assign rdy_s3    = ~v_s3 | rdy_s4;
	assign trk_ready = rdy_s3;
	assign take_s6   = v_s6 & rdy_s7;

	always_comb begin
		y_c  = {trk.steps_len, 4'd0} + SPD_BIAS;
		py_c = 52'(y_c) * 52'(RCP_375);
		a_c  = trk.total_len[39:21];
		b_c  = trk.total_len[20:1];
		pa_c = 41'(a_c) * 41'(RCP_5_HI);

		qy_c = py_s3[51:32];
		ry_c = 10'(y_s3 - 28'(qy_c) * 28'(DIV_375));
		qa_c = pa_s3[40:24];
		ra_c = 4'(a_s3 - 19'(qa_c) * 19'(DIV_5));

		// estimates run low by at most one: bump where the remainder allows
		spd_c   = qy_s4 + 20'(ry_s4 >= 10'(DIV_375));
		speed_c = (|spd_c[19:16]) ? 16'hFFFF : spd_c[15:0];
		ra_hi   = (ra_s4 >= 4'(DIV_5));
		qa_fix  = qa_s4 + 17'(ra_hi);
		ra_fix  = ra_hi ? ra_s4 - 4'(DIV_5) : ra_s4;
		w_c     = {ra_fix[2:0], b_s4};
		pw_c    = 47'(w_c) * 47'(RCP_5_LO);

		qw_c = pw_s5[45:26];
		rw_c = 4'(w_s5 - 23'(qw_c) * 23'(DIV_5));

		qw_fix = qw_s6 + 20'(rw_s6 >= 4'(DIV_5));
		dist_w = {qa_s6, qw_fix};
		dist_c = (|dist_w[36:32]) ? 32'hFFFF_FFFF : dist_w[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (rdy_s3) v_s3 <= trk_valid;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_s5) v_s5 <= v_s4;
			if (rdy_s6) v_s6 <= v_s5;
			if (rdy_s7) v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			meta_s3 <= trk.meta;
			y_s3    <= y_c;
			py_s3   <= py_c;
			a_s3    <= a_c;
			b_s3    <= b_c;
			pa_s3   <= pa_c;
		end
		if (rdy_s4) begin
			meta_s4 <= meta_s3;
			qy_s4   <= qy_c;
			ry_s4   <= ry_c;
			qa_s4   <= qa_c;
			ra_s4   <= ra_c;
			b_s4    <= b_s3;
		end
		if (rdy_s5) begin
			meta_s5  <= meta_s4;
			speed_s5 <= speed_c;
			qa_s5    <= qa_fix;
			w_s5     <= w_c;
			pw_s5    <= pw_c;
		end
		if (rdy_s6) begin
			meta_s6  <= meta_s5;
			speed_s6 <= speed_s5;
			qa_s6    <= qa_s5;
			qw_s6    <= qw_c;
			rw_s6    <= rw_c;
		end
		if (rdy_s7) begin
			if (meta_s6.closed) begin
				cad_s7  <= meta_s6.cadence;
				spd_s7  <= speed_s6;
				dist_s7 <= dist_c;
				run_s7  <= meta_s6.running;
			end else begin
				cad_s7  <= last_cad_q;
				spd_s7  <= last_spd_q;
				dist_s7 <= last_dist_q;
				run_s7  <= last_run_q;
			end
			total_s7  <= meta_s6.total;
			closed_s7 <= meta_s6.closed;
		end
	end

	// latch window results as the closing word moves into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_cad_q  <= 16'd0;
			last_spd_q  <= 16'd0;
			last_dist_q <= 32'd0;
			last_run_q  <= 1'b0;
		end else if (take_s6 && meta_s6.closed) begin
			last_cad_q  <= meta_s6.cadence;
			last_spd_q  <= speed_s6;
			last_dist_q <= dist_c;
			last_run_q  <= meta_s6.running;
		end
	end

	assign result.valid         = v_s7;
	assign result.cadence       = cad_s7;
	assign result.speed_q8      = spd_s7;
	assign result.distance_dm   = dist_s7;
	assign result.running       = run_s7;
	assign result.step_total    = total_s7;
	assign result.window_closed = closed_s7;

	a_out_matches_latch: assert property (@(posedge clk) disable iff (!arst_n)
		v_s7 |-> cad_s7 == last_cad_q && spd_s7 == last_spd_q
			&& dist_s7 == last_dist_q && run_s7 == last_run_q)
		else $error("result word out of step with latched window values");

	a_close_reaches_out: assert property (@(posedge clk) disable iff (!arst_n)
		take_s6 && meta_s6.closed |=> v_s7 && closed_s7)
		else $error("closing word lost on its way out");

endmodule

// File: sim/step_cadence_speed_window_unit_tb.sv
`timescale 1ns / 1ps

module step_cadence_speed_window_unit_tb;
	import scsw_pkg::*;

	localparam int HOLD_LEN   = 400;
	localparam int QUIET_MAX  = 4000;
	localparam int DRAIN_WAIT = 12;

	typedef struct {
		op_t         op;
		logic [31:0] now_ms;
		logic        is_motion;
		logic        vibrating;
	} step_item_t;

	typedef struct {
		logic [15:0] cadence;
		logic [15:0] speed_q8;
		logic [31:0] distance_dm;
		logic        running;
		logic [31:0] step_total;
		logic        window_closed;
	} step_report_t;

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [CFG_AW-1:0]   paddr;
	logic [31:0]         pwdata;
	logic [31:0]         prdata;
	logic                pready;

	scsw_in_if  in_ch ();
	scsw_out_if out_ch ();

	step_cadence_speed_window_unit i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.item    (in_ch),
		.result  (out_ch)
	);

	step_item_t   pend_q[$];
	step_report_t window_reports_q[$];

	// tracker state, mirrors the block
	logic [7:0]  cfg_len;
	logic [15:0] cfg_thr;
	logic [15:0] win_cnt;
	logic [31:0] win_start;
	logic [31:0] tot_steps;
	logic [15:0] lat_cad;
	logic [15:0] lat_spd;
	logic [31:0] lat_dist;
	logic        lat_run;

	// window start as seen by the stimulus generator
	logic [31:0] gen_start;
	int          queued_total;

	int          send_idle;
	int          recv_stall;
	logic        hold_on;
	int          hold_cnt;
	int          quiet_cnt;
	int          mismatch_cnt;
	int          words_in;
	int          words_out;
	int          closes_seen;
	step_report_t got;
	step_report_t want;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic advance_tracker(input step_item_t it);
		logic [31:0]  age;
		logic [63:0]  spd;
		logic [63:0]  dist_v;
		step_report_t r;
		r.window_closed = 1'b0;
		if (it.op == OP_EVENT) begin
			if (it.is_motion && !it.vibrating) begin
				if (win_cnt != 16'hFFFF)
					win_cnt = win_cnt + 16'd1;
				tot_steps = tot_steps + 32'd1;
			end
		end else begin
			age = it.now_ms - win_start;
			if (age > WINDOW_MS) begin
				spd    = (64'(win_cnt) * 64'(cfg_len) * 64'd256 + 64'd3000) / 64'd6000;
				dist_v = (64'(tot_steps) * 64'(cfg_len)) / 64'd10;
				lat_cad  = win_cnt;
				lat_spd  = (spd > 64'hFFFF) ? 16'hFFFF : spd[15:0];
				lat_dist = (dist_v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : dist_v[31:0];
				lat_run  = (win_cnt >= cfg_thr);
				win_cnt  = 16'd0;
				win_start = it.now_ms;
				r.window_closed = 1'b1;
			end
		end
		r.cadence     = lat_cad;
		r.speed_q8    = lat_spd;
		r.distance_dm = lat_dist;
		r.running     = lat_run;
		r.step_total  = tot_steps;
		window_reports_q.push_back(r);
	endtask

	task automatic check_field(input string name, input logic [31:0] exp_v,
		input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			mismatch_cnt++;
		end
	endtask

	// sender: hold the word until taken, predict on acceptance
	always @(posedge clk) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				advance_tracker('{in_ch.op, in_ch.now_ms, in_ch.is_motion, in_ch.vibrating});
				words_in++;
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (pend_q.size() != 0 && $urandom_range(99) >= send_idle) begin
					step_item_t nx;
					nx = pend_q.pop_front();
					in_ch.valid     <= 1'b1;
					in_ch.op        <= nx.op;
					in_ch.now_ms    <= nx.now_ms;
					in_ch.is_motion <= nx.is_motion;
					in_ch.vibrating <= nx.vibrating;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// receiver: random stalls, plus one long hold-off
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else if (hold_on && hold_cnt < HOLD_LEN) begin
			out_ch.ready <= 1'b0;
			hold_cnt <= hold_cnt + 1;
		end else begin
			out_ch.ready <= ($urandom_range(99) >= recv_stall);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			words_out++;
			got = '{out_ch.cadence, out_ch.speed_q8, out_ch.distance_dm, out_ch.running,
				out_ch.step_total, out_ch.window_closed};
			if (window_reports_q.size() == 0) begin
				$error("result word with no expectation pending");
				mismatch_cnt++;
			end else begin
				want = window_reports_q.pop_front();
				check_field("cadence", 32'(want.cadence), 32'(got.cadence));
				check_field("speed_q8", 32'(want.speed_q8), 32'(got.speed_q8));
				check_field("distance_dm", want.distance_dm, got.distance_dm);
				check_field("running", 32'(want.running), 32'(got.running));
				check_field("step_total", want.step_total, got.step_total);
				check_field("window_closed", 32'(want.window_closed), 32'(got.window_closed));
				if (want.window_closed)
					closes_seen++;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
				quiet_cnt <= 0;
			end else if (quiet_cnt >= QUIET_MAX) begin
				$display("timeout: no word moved for %0d cycles", QUIET_MAX);
				$display("RESULT: ERROR");
				$finish;
			end else begin
				quiet_cnt <= quiet_cnt + 1;
			end
		end
	end

	task automatic queue_item(input op_t op, input logic [31:0] now,
		input logic mot, input logic vib);
		if (op == OP_EVAL && (now - gen_start) > WINDOW_MS)
			gen_start = now;
		pend_q.push_back('{op, now, mot, vib});
		queued_total++;
	endtask

	task automatic reg_write(input reg_idx_t idx, input logic [31:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= CFG_AW'(idx) << 2;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx == REG_STEP_LEN)
			cfg_len = value[7:0];
		else
			cfg_thr = value[15:0];
	endtask

	task automatic set_regs(input logic [7:0] len, input logic [15:0] thr);
		// random upper bits must be dropped by the block
		reg_write(REG_STEP_LEN, {24'($urandom_range(24'hFFFFFF)), len});
		reg_write(REG_RUN_THR, {16'($urandom_range(16'hFFFF)), thr});
	endtask

	task automatic drain;
		do
			@(negedge clk);
		while (pend_q.size() != 0 || in_ch.valid || window_reports_q.size() != 0);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	// mostly full windows of events closed by an evaluate, the rest noise
	task automatic queue_random(input int n);
		int stop_at;
		int nev;
		stop_at = queued_total + n;
		while (queued_total < stop_at) begin
			if ($urandom_range(99) < 80) begin
				nev = $urandom_range(40);
				repeat (nev)
					queue_item(OP_EVENT, $urandom, ($urandom_range(99) < 85),
						($urandom_range(99) < 10));
				if ($urandom_range(99) < 15)
					queue_item(OP_EVAL, gen_start + $urandom_range(60000),
						1'($urandom_range(1)), 1'($urandom_range(1)));
				if ($urandom_range(99) < 10)
					queue_item(OP_EVAL, gen_start + WINDOW_MS, 1'($urandom_range(1)),
						1'($urandom_range(1)));
				queue_item(OP_EVAL, gen_start + WINDOW_MS + 1 + $urandom_range(3000),
					1'($urandom_range(1)), 1'($urandom_range(1)));
			end else begin
				queue_item(op_t'($urandom_range(1)), $urandom, 1'($urandom_range(1)),
					1'($urandom_range(1)));
			end
		end
	endtask

	task automatic set_idle(input int s_pct, input int r_pct);
		send_idle  <= s_pct;
		recv_stall <= r_pct;
		@(negedge clk);
	endtask

	initial begin
		arst_n          = 1'b0;
		psel            = 1'b0;
		penable         = 1'b0;
		pwrite          = 1'b0;
		paddr           = '0;
		pwdata          = '0;
		in_ch.valid     = 1'b0;
		in_ch.op        = OP_EVENT;
		in_ch.now_ms    = '0;
		in_ch.is_motion = 1'b0;
		in_ch.vibrating = 1'b0;
		out_ch.ready    = 1'b0;
		cfg_len         = STEP_LEN_RST;
		cfg_thr         = RUN_THR_RST;
		win_cnt         = '0;
		win_start       = '0;
		tot_steps       = '0;
		lat_cad         = '0;
		lat_spd         = '0;
		lat_dist        = '0;
		lat_run         = 1'b0;
		gen_start       = '0;
		queued_total    = 0;
		send_idle       = 0;
		recv_stall      = 0;
		hold_on         = 1'b0;
		hold_cnt        = 0;
		quiet_cnt       = 0;
		mismatch_cnt    = 0;
		words_in        = 0;
		words_out       = 0;
		closes_seen     = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed, reset register values
		queue_item(OP_EVAL, 32'd0, 1'b0, 1'b0);
		queue_item(OP_EVAL, WINDOW_MS, 1'b0, 1'b0);
		queue_item(OP_EVENT, 32'hFFFF_FFFF, 1'b0, 1'b0);
		queue_item(OP_EVENT, 32'd0, 1'b0, 1'b1);
		queue_item(OP_EVENT, 32'h5555_5555, 1'b1, 1'b1);
		repeat (5)
			queue_item(OP_EVENT, $urandom, 1'b1, 1'b0);
		queue_item(OP_EVAL, WINDOW_MS + 1, 1'b1, 1'b1);
		queue_item(OP_EVENT, 32'hAAAA_AAAA, 1'b1, 1'b0);
		queue_item(OP_EVAL, 2 * WINDOW_MS + 1, 1'b1, 1'b0);
		queue_item(OP_EVAL, 32'hFFFF_FFFF, 1'b0, 1'b1);
		repeat (3)
			queue_item(OP_EVENT, 32'hFFFF_FFFF, 1'b1, 1'b0);
		// wrapped age just above the start, then just past the window
		queue_item(OP_EVAL, 32'd100, 1'b0, 1'b0);
		queue_item(OP_EVAL, WINDOW_MS, 1'b0, 1'b0);
		queue_item(OP_EVAL, 32'd0, 1'b1, 1'b1);
		drain();

		// no idling, long receiver hold-off to back up the input
		set_regs(8'd255, 16'd0);
		hold_on <= 1'b1;
		@(negedge clk);
		queue_random(245);
		drain();

		// threshold out of reach, running stays low
		set_regs(8'd255, 16'hFFFF);
		repeat (30)
			queue_item(OP_EVENT, $urandom, 1'b1, 1'b0);
		queue_item(OP_EVAL, gen_start + WINDOW_MS + 1, 1'b0, 1'b0);
		drain();

		set_idle(83, 0);
		set_regs(8'd0, 16'($urandom_range(40)));
		queue_random(245);
		drain();

		set_idle(0, 83);
		set_regs(8'($urandom_range(255)), 16'($urandom_range(40)));
		queue_random(245);
		drain();

		set_idle(24, 24);
		set_regs(8'($urandom_range(1, 120)), 16'($urandom_range(1, 30)));
		queue_random(245);
		drain();

		$display("covered %0d words in, %0d results out, %0d windows closed",
			words_in, words_out, closes_seen);
		$display("settings: step length 0/255/random, threshold 0/65535/random, four idle mixes");
		if (mismatch_cnt == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// File: files.f
hw/rtl/scsw_pkg.sv
hw/rtl/scsw_if.sv
hw/rtl/scsw_cfg.sv
hw/rtl/scsw_track.sv
hw/rtl/scsw_math.sv
hw/rtl/step_cadence_speed_window_unit.sv
sim/step_cadence_speed_window_unit_tb.sv
